/* src/bpl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_pkg
// Shared types and constants of the BSP point leaf locator.
// ----------------------------------------------------------------------------
package bpl_pkg;

  // default table sizes
  localparam int DEF_NODE_COUNT  = 1024;
  localparam int DEF_PLANE_COUNT = 1024;
  localparam int DEF_LEAF_COUNT  = 1024;

  // field widths
  localparam int IDX_W    = 10;
  localparam int CHILD_W  = 11;
  localparam int NORM_W   = 16;
  localparam int COORD_W  = 32;
  localparam int DIV_W    = 5;
  localparam int IDX_SPAN = 1 << IDX_W;

  localparam int IN_DATA_W  = 224;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 1;

  localparam logic [DIV_W-1:0] DIVISOR_RESET = 5'd10;

  // command queue between front and back
  localparam int QDEPTH = 2;

  // stored entry widths
  localparam int NODE_W   = IDX_W + 2 * CHILD_W;
  localparam int NORMAL_W = 3 * NORM_W;

  typedef enum logic [1:0] {
    ACT_NODE   = 2'd0,
    ACT_PLANE  = 2'd1,
    ACT_LOCATE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CMD_NODE,
    CMD_PLANE,
    CMD_LOCATE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic [IDX_W-1:0]           index;
    logic [IDX_W-1:0]           plane;
    logic signed [CHILD_W-1:0]  front;
    logic signed [CHILD_W-1:0]  back;
    logic signed [NORM_W-1:0]   nx;
    logic signed [NORM_W-1:0]   ny;
    logic signed [NORM_W-1:0]   nz;
    logic signed [COORD_W-1:0]  offset;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
    logic signed [COORD_W-1:0]  pz;
  } cmd_t;

  // entries an index field can reach
  function automatic int table_depth(input int count);
    return (count < IDX_SPAN) ? count : IDX_SPAN;
  endfunction

endpackage

/* src/bpl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/bpl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_front
// Accepts input transactions, drops those that do nothing and queues
// table writes and locate requests for the walker.
// ----------------------------------------------------------------------------
module bpl_front #(
  parameter int NODE_COUNT  = 1024,
  parameter int PLANE_COUNT = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bpl_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [bpl_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                             head_valid,
  output bpl_pkg::cmd_t                    head,
  input  logic                             head_pop
);
  import bpl_pkg::*;

  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  cmd_t             q_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r,  count_nxt;

  cmd_t cmd;
  logic keep;
  logic push;
  logic pop;

  // unpack and classify
  always_comb begin
    cmd.index  = in_tdata[9:0];
    cmd.plane  = in_tdata[19:10];
    cmd.front  = $signed(in_tdata[30:20]);
    cmd.back   = $signed(in_tdata[41:31]);
    cmd.nx     = $signed(in_tdata[57:42]);
    cmd.ny     = $signed(in_tdata[73:58]);
    cmd.nz     = $signed(in_tdata[89:74]);
    cmd.offset = $signed(in_tdata[121:90]);
    cmd.px     = $signed(in_tdata[153:122]);
    cmd.py     = $signed(in_tdata[185:154]);
    cmd.pz     = $signed(in_tdata[217:186]);
    cmd.kind   = CMD_LOCATE;
    keep       = 1'b0;
    unique case (action_t'(in_tuser))
      ACT_NODE: begin
        cmd.kind = CMD_NODE;
        keep     = 32'(cmd.index) < NODE_COUNT;
      end
      ACT_PLANE: begin
        cmd.kind = CMD_PLANE;
        keep     = 32'(cmd.index) < PLANE_COUNT;
      end
      ACT_LOCATE: begin
        cmd.kind = CMD_LOCATE;
        keep     = 1'b1;
      end
      default: begin
        // unused action code: swallowed
        keep = 1'b0;
      end
    endcase
  end

  assign in_tready  = count_r != QCW'(QDEPTH);
  assign push       = in_tvalid && in_tready && keep;
  assign head_valid = count_r != '0;
  assign pop        = head_pop && head_valid;
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QDEPTH))
    else $error("command queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> head_valid)
    else $error("pop from empty command queue");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == QCW'(QDEPTH) && !head_pop) |=> !in_tready)
    else $error("full queue took a transaction");

endmodule

/* src/bpl_walker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_walker
// Carries out queued commands: table writes, and tree walks that test one
// node per pass through the plane arithmetic.
// ----------------------------------------------------------------------------
module bpl_walker #(
  parameter int NODE_COUNT  = 1024,
  parameter int PLANE_COUNT = 1024,
  parameter int LEAF_COUNT  = 1024
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        cfg_we,
  input  logic [bpl_pkg::DIV_W-1:0]                   cfg_wdata,
  input  logic                                        head_valid,
  input  bpl_pkg::cmd_t                               head,
  output logic                                        head_pop,
  output logic                                        node_we,
  output logic [$clog2(bpl_pkg::table_depth(NODE_COUNT))-1:0]  node_waddr,
  output logic [bpl_pkg::NODE_W-1:0]                  node_wdata,
  output logic [$clog2(bpl_pkg::table_depth(NODE_COUNT))-1:0]  node_raddr,
  input  logic [bpl_pkg::NODE_W-1:0]                  node_rdata,
  output logic                                        plane_we,
  output logic [$clog2(bpl_pkg::table_depth(PLANE_COUNT))-1:0] plane_waddr,
  output logic [bpl_pkg::NORMAL_W-1:0]                normal_wdata,
  output logic [bpl_pkg::COORD_W-1:0]                 offset_wdata,
  output logic [$clog2(bpl_pkg::table_depth(PLANE_COUNT))-1:0] plane_raddr,
  input  logic [bpl_pkg::NORMAL_W-1:0]                normal_rdata,
  input  logic [bpl_pkg::COORD_W-1:0]                 offset_rdata,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  output logic [bpl_pkg::IDX_W-1:0]                   out_leaf,
  output logic                                        out_status
);
  import bpl_pkg::*;

  localparam int NAW  = $clog2(table_depth(NODE_COUNT));
  localparam int PAW  = $clog2(table_depth(PLANE_COUNT));
  localparam int SW   = $clog2(NODE_COUNT + 1);
  localparam int PRW  = NORM_W + COORD_W;
  localparam int DOTW = PRW + 2;
  localparam int SCW  = DOTW + DIV_W + 1;
  localparam int THW  = COORD_W + 14;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_NODE,
    S_PLANE,
    S_SUM,
    S_SCALE,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [DIV_W-1:0]          div_r, div_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]          out_leaf_r, out_leaf_nxt;
  logic                      out_status_r, out_status_nxt;

  logic [IDX_W-1:0]          cur_r, cur_nxt;
  logic [SW-1:0]             steps_r, steps_nxt;
  logic signed [COORD_W-1:0] px_r, py_r, pz_r, px_nxt, py_nxt, pz_nxt;
  logic signed [CHILD_W-1:0] front_r, back_r, front_nxt, back_nxt;
  logic signed [COORD_W-1:0] offset_r, offset_nxt;
  logic signed [PRW-1:0]     prod_x_r, prod_y_r, prod_z_r;
  logic signed [PRW-1:0]     prod_x_nxt, prod_y_nxt, prod_z_nxt;
  logic signed [DOTW-1:0]    dot_r, dot_nxt;
  logic signed [SCW-1:0]     scaled_r, scaled_nxt;
  logic [IDX_W-1:0]          res_leaf_r, res_leaf_nxt;
  logic                      res_status_r, res_status_nxt;

  logic signed [NORM_W-1:0]  nx, ny, nz;
  logic signed [THW-1:0]     thresh;
  logic                      go_front;
  logic signed [CHILD_W-1:0] child;
  logic [IDX_W-1:0]          leaf;
  logic [IDX_W-1:0]          node_plane;
  logic                      out_free;

  assign nx         = $signed(normal_rdata[NORM_W-1:0]);
  assign ny         = $signed(normal_rdata[2*NORM_W-1:NORM_W]);
  assign nz         = $signed(normal_rdata[3*NORM_W-1:2*NORM_W]);
  assign node_plane = node_rdata[IDX_W-1:0];
  assign thresh     = $signed({offset_r, 14'b0});
  assign go_front   = scaled_r >= thresh;
  assign child      = go_front ? front_r : back_r;
  assign leaf       = ~child[IDX_W-1:0];
  assign out_free   = !out_valid_r || out_tready;

  // table writes straight from the queue head
  assign head_pop     = (state_r == S_IDLE) && head_valid;
  assign node_we      = head_pop && (head.kind == CMD_NODE);
  assign node_waddr   = head.index[NAW-1:0];
  assign node_wdata   = {head.back, head.front, head.plane};
  assign plane_we     = head_pop && (head.kind == CMD_PLANE);
  assign plane_waddr  = head.index[PAW-1:0];
  assign normal_wdata = {head.nz, head.ny, head.nx};
  assign offset_wdata = head.offset;
  assign node_raddr   = cur_r[NAW-1:0];
  assign plane_raddr  = node_plane[PAW-1:0];

  always_comb begin
    state_nxt      = state_r;
    div_nxt        = cfg_we ? cfg_wdata : div_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_leaf_nxt   = out_leaf_r;
    out_status_nxt = out_status_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    pz_nxt         = pz_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    offset_nxt     = offset_r;
    prod_x_nxt     = nx * px_r;
    prod_y_nxt     = ny * py_r;
    prod_z_nxt     = nz * pz_r;
    dot_nxt        = prod_x_r + prod_y_r + prod_z_r;
    scaled_nxt     = $signed({1'b0, div_r}) * dot_r;
    res_leaf_nxt   = res_leaf_r;
    res_status_nxt = res_status_r;

    unique case (state_r)
      S_IDLE: begin
        if (head_pop && head.kind == CMD_LOCATE) begin
          px_nxt    = head.px;
          py_nxt    = head.py;
          pz_nxt    = head.pz;
          cur_nxt   = '0;
          steps_nxt = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (32'(steps_r) == NODE_COUNT || 32'(cur_r) >= NODE_COUNT) begin
          res_leaf_nxt   = '0;
          res_status_nxt = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          state_nxt = S_NODE;
        end
      end
      S_NODE: begin
        front_nxt = $signed(node_rdata[IDX_W+CHILD_W-1:IDX_W]);
        back_nxt  = $signed(node_rdata[NODE_W-1:IDX_W+CHILD_W]);
        if (32'(node_plane) >= PLANE_COUNT) begin
          res_leaf_nxt   = '0;
          res_status_nxt = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          state_nxt = S_PLANE;
        end
      end
      S_PLANE: begin
        offset_nxt = $signed(offset_rdata);
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (child[CHILD_W-1]) begin
          res_leaf_nxt   = (32'(leaf) < LEAF_COUNT) ? leaf : '0;
          res_status_nxt = !(32'(leaf) < LEAF_COUNT);
          state_nxt      = S_EMIT;
        end else begin
          cur_nxt   = child[IDX_W-1:0];
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_leaf_nxt   = res_leaf_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    pz_r         <= pz_nxt;
    front_r      <= front_nxt;
    back_r       <= back_nxt;
    offset_r     <= offset_nxt;
    prod_x_r     <= prod_x_nxt;
    prod_y_r     <= prod_y_nxt;
    prod_z_r     <= prod_z_nxt;
    dot_r        <= dot_nxt;
    scaled_r     <= scaled_nxt;
    res_leaf_r   <= res_leaf_nxt;
    res_status_r <= res_status_nxt;
    out_leaf_r   <= out_leaf_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_r       <= DIVISOR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_r       <= div_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_leaf   = out_leaf_r;
  assign out_status = out_status_r;

  a_error_leaf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_leaf_r == '0))
    else $error("error result carries a leaf");

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_EMIT) |-> (32'(steps_r) <= NODE_COUNT))
    else $error("walk step count past node count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_leaf_r)
      && $stable(out_status_r)))
    else $error("pending result lost or changed");

endmodule

/* src/bsp_point_leaf_locator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_point_leaf_locator
// Finds the BSP leaf that holds a 3-D point, walking a node and plane table.
// ----------------------------------------------------------------------------
// in_*  : one transaction per item. in_tuser selects node write, plane write
//         or locate; writes give no result, locate gives exactly one.
// out_* : leaf index in out_tdata, error flag in out_tuser.
// cfg_* : distance divisor; the user must write it only while the block is idle (not enforced).
// A two-entry command queue splits the input stage from the walker, so
// input transactions keep being taken while a walk runs or a result waits,
// until the queue is full. Writes are carried out in the walker straight
// from the queue head. A locate is queued and issued; each node visited then
// passes node read, plane read, products, sum, divisor scaling and side test,
// and the result register is loaded last. The node-per-pass loop through the
// plane arithmetic sets the rate; no command starts before the last result.
// Reset empties the queue and output register and sets the divisor to 10.
// Table contents are undefined until written; there is no clearing pass.
// A stalled receiver holds the result; the walker waits, then the queue
// fills and in_tready drops.
// ----------------------------------------------------------------------------
module bsp_point_leaf_locator #(
  parameter int NODE_COUNT  = bpl_pkg::DEF_NODE_COUNT,
  parameter int PLANE_COUNT = bpl_pkg::DEF_PLANE_COUNT,
  parameter int LEAF_COUNT  = bpl_pkg::DEF_LEAF_COUNT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bpl_pkg::DIV_W-1:0]         cfg_wdata,  // distance_divisor
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // table_index, node_plane, node_front, node_back, normal_x, normal_y,
  // normal_z, plane_offset, point_x, point_y, point_z
  input  logic [bpl_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [bpl_pkg::IN_USER_W-1:0]     in_tuser,   // action
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bpl_pkg::OUT_DATA_W-1:0]    out_tdata,  // leaf_index
  output logic [bpl_pkg::OUT_USER_W-1:0]    out_tuser   // status
);
  import bpl_pkg::*;

  localparam int NodeDepth  = table_depth(NODE_COUNT);
  localparam int PlaneDepth = table_depth(PLANE_COUNT);
  localparam int NAW        = $clog2(NodeDepth);
  localparam int PAW        = $clog2(PlaneDepth);

  logic                 head_valid;
  cmd_t                 head;
  logic                 head_pop;
  logic                 node_we;
  logic [NAW-1:0]       node_waddr, node_raddr;
  logic [NODE_W-1:0]    node_wdata, node_rdata;
  logic                 plane_we;
  logic [PAW-1:0]       plane_waddr, plane_raddr;
  logic [NORMAL_W-1:0]  normal_wdata, normal_rdata;
  logic [COORD_W-1:0]   offset_wdata, offset_rdata;
  logic [IDX_W-1:0]     out_leaf;
  logic                 out_status;

  bpl_front #(
    .NODE_COUNT  (NODE_COUNT),
    .PLANE_COUNT (PLANE_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  bpl_ram #(.WIDTH(NODE_W), .DEPTH(NodeDepth)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  bpl_ram #(.WIDTH(NORMAL_W), .DEPTH(PlaneDepth)) u_normal_ram (
    .clk   (clk),
    .we    (plane_we),
    .waddr (plane_waddr),
    .wdata (normal_wdata),
    .raddr (plane_raddr),
    .rdata (normal_rdata)
  );

  bpl_ram #(.WIDTH(COORD_W), .DEPTH(PlaneDepth)) u_offset_ram (
    .clk   (clk),
    .we    (plane_we),
    .waddr (plane_waddr),
    .wdata (offset_wdata),
    .raddr (plane_raddr),
    .rdata (offset_rdata)
  );

  bpl_walker #(
    .NODE_COUNT  (NODE_COUNT),
    .PLANE_COUNT (PLANE_COUNT),
    .LEAF_COUNT  (LEAF_COUNT)
  ) u_walker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .head_valid   (head_valid),
    .head         (head),
    .head_pop     (head_pop),
    .node_we      (node_we),
    .node_waddr   (node_waddr),
    .node_wdata   (node_wdata),
    .node_raddr   (node_raddr),
    .node_rdata   (node_rdata),
    .plane_we     (plane_we),
    .plane_waddr  (plane_waddr),
    .normal_wdata (normal_wdata),
    .offset_wdata (offset_wdata),
    .plane_raddr  (plane_raddr),
    .normal_rdata (normal_rdata),
    .offset_rdata (offset_rdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_leaf     (out_leaf),
    .out_status   (out_status)
  );

  assign out_tdata = {{(OUT_DATA_W - IDX_W){1'b0}}, out_leaf};
  assign out_tuser = out_status;

endmodule
